[design/psh_pkg.sv]
// Shared types and constants for the polynomial string hash block.
`timescale 1ns / 1ps

package psh_pkg;

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 31;
    localparam int CFG_IDX_W = 1;

    typedef logic [WORD_W-1:0] t_word;

    // One queued input byte with its end-of-string mark
    typedef struct packed {
        logic [BYTE_W-1:0] char_byte;
        logic              end_of_string;
    } t_item;

    localparam int ITEM_W = $bits(t_item);

    // Configuration write transaction
    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        t_word                data;
    } t_cfg_wr;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_BASE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_MODULUS = 1'd1;

    localparam t_word BASE_RST    = 31'd31;
    localparam t_word MODULUS_RST = 31'd1000000007;

endpackage

[design/polynomial_string_hash_mod_top.sv]
// Top level of the polynomial string hash block: front queue, hash engine, result queue.
// Per byte: a pop, 31 shift-add multiplier steps, a sum, and on a last byte an output push.
// The first byte after a modulus write is preceded by a reduction of the held state to the new modulus.
// A new byte is popped only once the last one is through; a hash push waits while the result queue is full.
// Reset: synchronous, active low; empties both queues, base 31, modulus 1000000007, state 0 and 1.
`timescale 1ns / 1ps

module polynomial_string_hash_mod_top
    import psh_pkg::*;
#(
    parameter int IN_DEPTH  = 2,
    parameter int OUT_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte input, queue style
    input  logic                 push,
    output logic                 full,
    input  logic [BYTE_W-1:0]    i_char_byte,
    input  logic                 i_end_of_string,
    // hash output, queue style
    output logic                 empty,
    input  logic                 pop,
    output logic [WORD_W-1:0]    o_hash_value,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    t_item                 w_in_item;
    logic [ITEM_W-1:0]     w_q_data;
    logic                  w_q_empty;
    logic                  w_q_pop;
    t_cfg_wr               w_cfg;
    logic                  w_res_push;
    logic                  w_res_full;
    t_word                 w_res_hash;

    // Pack the byte transaction for the front queue
    assign w_in_item = '{char_byte: i_char_byte, end_of_string: i_end_of_string};

    // Bundle the configuration transaction for the engine
    assign w_cfg = '{valid: i_cfg_valid, index: i_cfg_index, data: i_cfg_data};

    // Front queue: absorb bytes while the engine works on an earlier one
    psh_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (IN_DEPTH)
    ) u_front_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_in_item),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_data),
        .o_empty (w_q_empty)
    );

    // Engine: one byte at a time, two modular products per byte run side by side
    psh_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .o_cfg_ready  (o_cfg_ready),
        .i_item       (t_item'(w_q_data)),
        .i_item_avail (!w_q_empty),
        .o_item_pop   (w_q_pop),
        .o_res_push   (w_res_push),
        .o_res_hash   (w_res_hash),
        .i_res_full   (w_res_full)
    );

    // Result queue: hold finished hashes so the engine can advance to the next string
    psh_fifo #(
        .WIDTH (WORD_W),
        .DEPTH (OUT_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_hash),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (o_hash_value),
        .o_empty (empty)
    );

endmodule

[design/psh_fifo.sv]
// Small synchronous queue used between the front, the engine and the result port.
`timescale 1ns / 1ps

module psh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[design/psh_engine.sv]
// Hash engine: configuration registers, hash state and the bit-serial modular multipliers.
`timescale 1ns / 1ps

module psh_engine
    import psh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    output logic    o_cfg_ready,
    input  t_item   i_item,
    input  logic    i_item_avail,
    output logic    o_item_pop,
    output logic    o_res_push,
    output t_word   o_res_hash,
    input  logic    i_res_full
);

    localparam int CNT_W = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WORD_W - 1);
    localparam logic [CNT_W-1:0] BYTE_CNT = CNT_W'(BYTE_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_MUL,
        S_SUM,
        S_OUT
    } t_state;

    t_state              r_state;
    t_word               r_base, r_mod;
    logic [WORD_W:0]     r_mod2;
    logic                r_dirty;
    t_word               r_sum, r_pow;
    t_word               r_acc_t, r_acc_p;
    t_word               r_sh_a, r_sh_b;
    logic [BYTE_W-1:0]   r_byte;
    logic                r_last;
    logic [CNT_W-1:0]    r_cnt;
    t_word               r_hash;

    t_word               n_red_t, n_red_p, n_mul_t, n_mul_p, n_sum;
    t_word               cfg_mod_eff;
    logic [WORD_W:0]     sum_raw;

    // acc = (2*acc + b*x) mod m, with acc < m and x < m
    function automatic t_word mul_step(t_word acc, logic b_in, t_word x, t_word m,
                                       logic [WORD_W:0] m2);
        logic [WORD_W+1:0] t;
        logic [WORD_W+1:0] d1;
        logic [WORD_W+1:0] d2;
        t  = {1'b0, acc, 1'b0} + (b_in ? {2'b00, x} : '0);
        d1 = t - {2'b00, m};
        d2 = t - {1'b0, m2};
        if (t >= {1'b0, m2}) begin
            return d2[WORD_W-1:0];
        end else if (t >= {2'b00, m}) begin
            return d1[WORD_W-1:0];
        end
        return t[WORD_W-1:0];
    endfunction

    // acc = (2*acc + b) mod m, with acc < m
    function automatic t_word red_step(t_word acc, logic b_in, t_word m);
        logic [WORD_W:0] t;
        logic [WORD_W:0] d;
        t = {acc, b_in};
        d = t - {1'b0, m};
        if (t >= {1'b0, m}) begin
            return d[WORD_W-1:0];
        end
        return t[WORD_W-1:0];
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_item_pop  = (r_state == S_IDLE) && i_item_avail;
    assign o_res_push  = (r_state == S_OUT);
    assign o_res_hash  = r_hash;

    assign cfg_mod_eff = (i_cfg.data == '0) ? t_word'(1) : i_cfg.data;

    assign n_red_t = red_step(r_acc_t, r_sh_a[WORD_W-1], r_mod);
    assign n_red_p = red_step(r_acc_p, r_sh_b[WORD_W-1], r_mod);
    assign n_mul_t = mul_step(r_acc_t, r_byte[BYTE_W-1], r_pow, r_mod, r_mod2);
    assign n_mul_p = mul_step(r_acc_p, r_sh_a[WORD_W-1], r_pow, r_mod, r_mod2);

    assign sum_raw = {1'b0, r_sum} + {1'b0, r_acc_t};
    assign n_sum   = (sum_raw >= {1'b0, r_mod}) ? WORD_W'(sum_raw - {1'b0, r_mod})
                                                : sum_raw[WORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base  <= BASE_RST;
            r_mod   <= MODULUS_RST;
            r_mod2  <= {MODULUS_RST, 1'b0};
            r_dirty <= 1'b0;
            r_sum   <= '0;
            r_pow   <= t_word'(1);
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_item_avail) begin
                        r_byte  <= i_item.char_byte;
                        r_last  <= i_item.end_of_string;
                        r_acc_t <= '0;
                        r_acc_p <= '0;
                        r_cnt   <= '0;
                        if (r_dirty) begin
                            // state may exceed a new modulus: reduce it first
                            r_sh_a  <= r_sum;
                            r_sh_b  <= r_pow;
                            r_state <= S_REDUCE;
                        end else begin
                            r_sh_a  <= r_base;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_REDUCE: begin
                    r_acc_t <= n_red_t;
                    r_acc_p <= n_red_p;
                    r_sh_a  <= r_sh_a << 1;
                    r_sh_b  <= r_sh_b << 1;
                    r_cnt   <= r_cnt + CNT_W'(1);
                    if (r_cnt == LAST_CNT) begin
                        r_sum   <= n_red_t;
                        r_pow   <= n_red_p;
                        r_dirty <= 1'b0;
                        r_acc_t <= '0;
                        r_acc_p <= '0;
                        r_sh_a  <= r_base;
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_acc_p <= n_mul_p;
                    r_sh_a  <= r_sh_a << 1;
                    if (r_cnt < BYTE_CNT) begin
                        r_acc_t <= n_mul_t;
                        r_byte  <= r_byte << 1;
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == LAST_CNT) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (r_last) begin
                        r_hash  <= n_sum;
                        r_sum   <= '0;
                        r_pow   <= t_word'(1);
                        r_state <= S_OUT;
                    end else begin
                        r_sum   <= n_sum;
                        r_pow   <= r_acc_p;
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_HASH_BASE: begin
                        r_base <= i_cfg.data;
                    end
                    CFG_HASH_MODULUS: begin
                        r_mod   <= cfg_mod_eff;
                        r_mod2  <= {cfg_mod_eff, 1'b0};
                        r_dirty <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

[design/psh_checker.sv]
// Port-level assertions for the polynomial string hash block, bound to the top level.
`timescale 1ns / 1ps

module psh_checker
    import psh_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input logic [WORD_W-1:0] o_hash_value,
    input logic              i_cfg_valid,
    input logic              o_cfg_ready
);

    // A waiting hash stays put until it is popped
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_hash_value)))
        else $error("waiting hash changed or vanished without a pop");

    // Reset leaves both queues empty
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // No hash can come out right after reset: every byte needs the full multiply pass
    a_no_early_result: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> ##2 empty)
        else $error("hash appeared too soon after reset");

    // Configuration writes are never back-pressured
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration transaction stalled");

endmodule

bind polynomial_string_hash_mod_top psh_checker u_psh_checker (.*);

[bench/tb_polynomial_string_hash_mod_top.sv]
// Self-checking testbench for the polynomial string hash block: a directed table, then random strings.
`timescale 1ns / 1ps

module tb_polynomial_string_hash_mod_top;
    import psh_pkg::*;

    localparam int N_ITEMS       = 1100;  // random bytes to send after the table
    localparam int STEADY_FROM   = 950;   // from here on neither side idles
    localparam int SETTLE_CYCLES = 250;   // bytes still in the front queue, plus a modulus reduction
    localparam int TAIL_CYCLES   = 100;
    localparam int WATCHDOG      = 2000;  // cycles without any transaction
    localparam int N_DIRECTED    = 32;
    localparam t_word WORD_MAX   = 31'h7FFFFFFF;

    typedef enum logic {ROW_BYTE, ROW_CFG} t_row_kind;

    // One row of the directed table. A byte row carries the byte in value[7:0];
    // known marks a hash that is typed in rather than predicted.
    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] index;
        t_word                value;
        logic                 last;
        logic                 known;
        t_word                known_hash;
    } t_stim_row;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 push            = 1'b0;
    logic                 full;
    logic [BYTE_W-1:0]    i_char_byte     = '0;
    logic                 i_end_of_string = 1'b0;
    logic                 empty;
    logic                 pop             = 1'b0;
    logic [WORD_W-1:0]    o_hash_value;
    logic                 i_cfg_valid     = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [WORD_W-1:0]    i_cfg_data      = '0;

    // Travel with each byte so the monitor sees them at the same edge as the byte
    logic  byte_known      = 1'b0;
    t_word byte_known_hash = '0;

    // Predictor state, updated at the handshakes only
    t_word cur_base;
    t_word cur_modulus;
    t_word acc_sum;
    t_word acc_power;
    t_word pending_hashes[$];

    int    errors      = 0;
    int    bytes_taken = 0;
    int    hashes_seen = 0;
    int    cfg_writes  = 0;
    int    quiet       = 0;
    int    pop_hold    = 0;
    bit    steady      = 1'b0;
    bit    moved;
    t_word want;
    t_word got;

    t_stim_row directed [N_DIRECTED];

    polynomial_string_hash_mod_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_char_byte     (i_char_byte),
        .i_end_of_string (i_end_of_string),
        .empty           (empty),
        .pop             (pop),
        .o_hash_value    (o_hash_value),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Fold one byte into the running hash; return the sum after this byte.
    // A zero modulus acts as one, so every hash then comes out zero.
    function automatic t_word absorb_byte(input logic [BYTE_W-1:0] b, input logic last);
        longint unsigned m;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned pw;
        m    = (cur_modulus == '0) ? 64'd1 : 64'(cur_modulus);
        term = (64'(b) * 64'(acc_power)) % m;
        sum  = (64'(acc_sum) + term) % m;
        pw   = (64'(acc_power) * 64'(cur_base)) % m;
        if (last) begin
            acc_sum   = '0;
            acc_power = 31'd1;
        end else begin
            acc_sum   = t_word'(sum);
            acc_power = t_word'(pw);
        end
        return t_word'(sum);
    endfunction

    // Monitor: check popped hashes, track register writes, predict from accepted bytes,
    // drive pop, and watch for a stuck block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_base    = BASE_RST;
            cur_modulus = MODULUS_RST;
            acc_sum     = '0;
            acc_power   = 31'd1;
            pop        <= 1'b0;
        end else begin
            moved = 1'b0;

            if (pop && !empty) begin
                moved = 1'b1;
                hashes_seen++;
                if (pending_hashes.size() == 0) begin
                    errors++;
                    $display("%0t: hash %0d popped while none was expected", $time, o_hash_value);
                end else begin
                    want = pending_hashes.pop_front();
                    if (o_hash_value !== want) begin
                        errors++;
                        $display("%0t: hash_value mismatch: expected %0d, actual %0d",
                                 $time, want, o_hash_value);
                    end
                end
            end

            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                cfg_writes++;
                case (i_cfg_index)
                    CFG_HASH_BASE:    cur_base    = i_cfg_data;
                    CFG_HASH_MODULUS: cur_modulus = i_cfg_data;
                    default: ;
                endcase
            end

            if (push && !full) begin
                moved = 1'b1;
                bytes_taken++;
                got = absorb_byte(i_char_byte, i_end_of_string);
                if (i_end_of_string)
                    pending_hashes.push_back(byte_known ? byte_known_hash : got);
            end

            // Stall the result side in short bursts until the steady tail
            if (steady) begin
                pop <= 1'b1;
            end else if (pop_hold != 0) begin
                pop <= 1'b0;
                pop_hold--;
            end else if ($urandom_range(0, 4) == 0) begin
                pop <= 1'b0;
                pop_hold = $urandom_range(0, 4);
            end else begin
                pop <= 1'b1;
            end

            quiet = moved ? 0 : quiet + 1;
            if (quiet >= WATCHDOG) begin
                $display("%0t: no transaction for %0d cycles, %0d hashes still expected",
                         $time, WATCHDOG, pending_hashes.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Offer one byte, after an optional idle burst; return at the accepting edge.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last,
                             input logic known, input t_word known_hash);
        if (!steady && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        push            <= 1'b1;
        i_char_byte     <= b;
        i_end_of_string <= last;
        byte_known      <= known;
        byte_known_hash <= known_hash;
        do @(posedge i_clk); while (full);
    endtask

    // Hold off until every hash is out and the engine has worked through any bytes of an
    // unfinished string, so that a register write lands on an idle block.
    task automatic drain();
        push <= 1'b0;
        while (pending_hashes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leave valid high; the caller drops it after the last write of a batch.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_word val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    initial begin
        int    sent;
        int    str_left;
        int    phase_len;
        t_word base;
        t_word modulus;
        logic  last;

        // Expected hashes typed in below hold at the reset base 31 and modulus 1000000007,
        // or follow directly from a modulus of one, or from a base of one.
        directed = '{
            '{ROW_BYTE, '0, 31'd0,   1'b1, 1'b1, 31'd0},     // zero byte alone
            '{ROW_BYTE, '0, 31'd255, 1'b1, 1'b1, 31'd255},   // high byte counts unsigned
            '{ROW_BYTE, '0, 31'd1,   1'b0, 1'b0, '0},
            '{ROW_BYTE, '0, 31'd2,   1'b1, 1'b1, 31'd63},    // 1 + 2*31
            '{ROW_BYTE, '0, 31'd255, 1'b0, 1'b0, '0},
            '{ROW_BYTE, '0, 31'd255, 1'b1, 1'b1, 31'd8160},  // 255 * 32
            '{ROW_BYTE, '0, 31'd128, 1'b0, 1'b0, '0},
            '{ROW_BYTE, '0, 31'd127, 1'b1, 1'b1, 31'd4065},  // 128 + 127*31
            '{ROW_CFG,  CFG_HASH_MODULUS, 31'd1, 1'b0, 1'b0, '0},
            '{ROW_BYTE, '0, 31'd200, 1'b1, 1'b1, 31'd0},     // modulus one
            '{ROW_CFG,  CFG_HASH_MODULUS, 31'd0, 1'b0, 1'b0, '0},
            '{ROW_BYTE, '0, 31'd77,  1'b0, 1'b0, '0},
            '{ROW_BYTE, '0, 31'd255, 1'b1, 1'b1, 31'd0},     // zero modulus acts as one
            '{ROW_CFG,  CFG_HASH_BASE,    31'd1,    1'b0, 1'b0, '0},
            '{ROW_CFG,  CFG_HASH_MODULUS, WORD_MAX, 1'b0, 1'b0, '0},
            '{ROW_BYTE, '0, 31'd255, 1'b0, 1'b0, '0},
            '{ROW_BYTE, '0, 31'd255, 1'b0, 1'b0, '0},
            '{ROW_BYTE, '0, 31'd1,   1'b1, 1'b1, 31'd511},   // base one: plain byte sum
            '{ROW_CFG,  CFG_HASH_BASE,    WORD_MAX, 1'b0, 1'b0, '0},  // base equal to modulus
            '{ROW_BYTE, '0, 31'd255, 1'b0, 1'b0, '0},
            '{ROW_BYTE, '0, 31'd255, 1'b0, 1'b0, '0},
            '{ROW_BYTE, '0, 31'd0,   1'b1, 1'b0, '0},
            '{ROW_CFG,  CFG_HASH_MODULUS, 31'd1000, 1'b0, 1'b0, '0},  // base far above modulus
            '{ROW_BYTE, '0, 31'd9,   1'b0, 1'b0, '0},
            '{ROW_BYTE, '0, 31'd250, 1'b1, 1'b0, '0},
            '{ROW_BYTE, '0, 31'd5,   1'b0, 1'b0, '0},
            // change both registers in the middle of a string
            '{ROW_CFG,  CFG_HASH_MODULUS, 31'd13, 1'b0, 1'b0, '0},
            '{ROW_CFG,  CFG_HASH_BASE,    31'd7,  1'b0, 1'b0, '0},
            '{ROW_BYTE, '0, 31'd6,   1'b0, 1'b0, '0},
            '{ROW_BYTE, '0, 31'd255, 1'b1, 1'b0, '0},
            '{ROW_CFG,  CFG_HASH_BASE,    BASE_RST,    1'b0, 1'b0, '0},
            '{ROW_CFG,  CFG_HASH_MODULUS, MODULUS_RST, 1'b0, 1'b0, '0}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (int k = 0; k < N_DIRECTED; k++) begin
            if (directed[k].kind == ROW_CFG) begin
                if (k == 0 || directed[k-1].kind != ROW_CFG)
                    drain();
                write_reg(directed[k].index, directed[k].value);
                if (k + 1 == N_DIRECTED || directed[k+1].kind != ROW_CFG)
                    i_cfg_valid <= 1'b0;
            end else begin
                send_byte(directed[k].value[BYTE_W-1:0], directed[k].last,
                          directed[k].known, directed[k].known_hash);
            end
        end

        // Random phases: a register setting, then well-formed strings of random bytes.
        // A phase may end inside a string, so the next setting applies mid-string.
        sent     = 0;
        str_left = 0;
        while (sent < N_ITEMS) begin
            drain();
            case ($urandom_range(0, 7))
                0: begin
                    base    = BASE_RST;
                    modulus = MODULUS_RST;
                end
                1: begin
                    base    = WORD_MAX;
                    modulus = WORD_MAX;
                end
                2: begin
                    base    = 31'd1;
                    modulus = t_word'($urandom_range(1, WORD_MAX));
                end
                3: begin
                    base    = t_word'($urandom_range(1, WORD_MAX));
                    modulus = t_word'($urandom_range(0, 1));
                end
                4: begin
                    base    = t_word'($urandom_range(1, WORD_MAX));
                    modulus = t_word'($urandom_range(2, 300));
                end
                default: begin
                    base    = t_word'($urandom_range(1, WORD_MAX));
                    modulus = t_word'($urandom_range(1, WORD_MAX));
                end
            endcase
            case ($urandom_range(0, 3))
                0: write_reg(CFG_HASH_BASE, base);
                1: write_reg(CFG_HASH_MODULUS, modulus);
                default: begin
                    write_reg(CFG_HASH_BASE, base);
                    write_reg(CFG_HASH_MODULUS, modulus);
                end
            endcase
            i_cfg_valid <= 1'b0;

            phase_len = $urandom_range(60, 140);
            repeat (phase_len) begin
                if (str_left == 0)
                    str_left = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                           : $urandom_range(1, 12);
                str_left--;
                last = (str_left == 0);
                send_byte(BYTE_W'($urandom_range(0, 255)), last, 1'b0, '0);
                sent++;
                if (sent >= STEADY_FROM)
                    steady = 1'b1;
            end
        end

        // Close the last string so its hash is checked too
        if (str_left != 0)
            send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
        push <= 1'b0;

        while (pending_hashes.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d bytes, %0d hashes and %0d register writes,",
                 bytes_taken, hashes_seen, cfg_writes);
        $display("including zero, unit and full-width moduli and mid-string setting changes.");
        if (errors == 0 && pending_hashes.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
